@@ hdl/an2i_pkg.sv @@
// package with phase codes, character constants and the digit classifier
`timescale 1ns / 1ps

package an2i_pkg;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SIGNED = 2'd1;
  localparam logic [1:0] PH_ZERO   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic CFG_RADIX = 1'b0;
  localparam logic CFG_SIZE  = 1'b1;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;

  localparam logic [4:0] RADIX_RST = 5'd10;
  localparam logic [1:0] SIZE_RST  = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } digit_t;

  function automatic digit_t digit_value(input logic [7:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = 8'd0;
    if (c >= CH_LC_A) begin
      d.val = c - CH_LC_A + 8'd10;
    end else if (c >= CH_UC_A) begin
      d.val = c - CH_UC_A + 8'd10;
    end else if (c >= CH_ZERO) begin
      d.val = c - CH_ZERO;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

@@ hdl/ascii_number_to_integer.sv @@
// streaming ascii number text to integer converter
// a result is registered in the result register when the item marked last fires from the input register
// throughput: one item per cycle, input register then one compute stage
// a stalled result stalls only the next last item and the items behind it; earlier items keep flowing
// reset: conversion state cleared, radix 10, size code 2, no items held
`timescale 1ns / 1ps

module ascii_number_to_integer
  import an2i_pkg::*;
#(
  parameter int ACC_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value
  output logic [1:0]  m_axis_tuser    // bogus, too_large
);

  localparam int EXT_W = (ACC_WIDTH > 33) ? ACC_WIDTH : 33;

  logic [4:0] radix_q;
  logic [1:0] size_q;

  logic       st_vld_q;
  logic [7:0] st_ch_q;
  logic       st_last_q;

  logic [ACC_WIDTH-1:0] acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic [4:0]           base_q, base_d;
  logic [1:0]           phase_q, phase_d;
  logic                 stop_q, stop_d;
  logic                 ds_q, ds_d;

  logic        m_vld_q;
  logic [31:0] m_val_q, m_val_d;
  logic [1:0]  m_user_q, m_user_d;

  logic fire;
  logic do_take;
  logic [4:0] eb;
  logic [4:0] tb;
  digit_t dv;
  logic [EXT_W-1:0] acc_ext, res_ext, limit;
  logic [31:0] smask;
  logic [ACC_WIDTH-1:0] prod;

  assign fire = st_vld_q && (!st_last_q || !m_vld_q || m_axis_tready);
  assign s_axis_tready = !st_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RST;
      size_q  <= SIZE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RADIX) begin
        radix_q <= cfg_data_i;
      end else begin
        size_q <= cfg_data_i[1:0];
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      st_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      st_ch_q   <= s_axis_tdata;
      st_last_q <= s_axis_tlast;
    end
  end

  assign dv   = digit_value(st_ch_q);
  assign eb   = (phase_q == PH_START) ? radix_q : base_q;
  assign prod = acc_q * ACC_WIDTH'(tb);

  always_comb begin
    acc_d   = acc_q;
    neg_d   = neg_q;
    base_d  = base_q;
    phase_d = phase_q;
    stop_d  = stop_q;
    ds_d    = ds_q;
    do_take = 1'b0;
    tb      = base_q;
    case (phase_q)
      PH_START, PH_SIGNED: begin
        if (phase_q == PH_START && st_ch_q == CH_MINUS) begin
          neg_d   = 1'b1;
          base_d  = eb;
          phase_d = PH_SIGNED;
        end else if (eb == 5'd0 && st_ch_q == CH_ZERO) begin
          base_d  = eb;
          phase_d = PH_ZERO;
        end else begin
          tb      = (eb == 5'd0) ? 5'd10 : eb;
          base_d  = tb;
          phase_d = PH_DIGITS;
          do_take = 1'b1;
        end
      end
      PH_ZERO: begin
        phase_d = PH_DIGITS;
        if (st_ch_q == CH_X) begin
          base_d = 5'd16;
        end else if (st_ch_q >= CH_ZERO && st_ch_q <= CH_NINE) begin
          tb      = 5'd8;
          base_d  = 5'd8;
          do_take = 1'b1;
        end else begin
          // dropped zero counts as a decimal digit, the character stops
          base_d = 5'd10;
          ds_d   = 1'b1;
          stop_d = 1'b1;
        end
      end
      default: begin
        do_take = 1'b1;
      end
    endcase

    if (do_take && !stop_q) begin
      if (!dv.ok || dv.val >= {3'b000, tb}) begin
        stop_d = 1'b1;
      end else begin
        acc_d = prod + ACC_WIDTH'(dv.val);
        ds_d  = 1'b1;
      end
    end

    // a lone zero left pending at the end is decimal zero
    if (st_last_q && phase_d == PH_ZERO) begin
      ds_d = 1'b1;
    end
  end

  always_comb begin
    acc_ext = EXT_W'(acc_d);
    res_ext = neg_d ? (~acc_ext + EXT_W'(1)) : acc_ext;
    case (size_q)
      SIZE_8: begin
        smask = 32'h0000_00ff;
        limit = neg_d ? EXT_W'(33'h0_0000_0080) : EXT_W'(33'h0_0000_00ff);
      end
      SIZE_16: begin
        smask = 32'h0000_ffff;
        limit = neg_d ? EXT_W'(33'h0_0000_8000) : EXT_W'(33'h0_0000_ffff);
      end
      default: begin
        smask = 32'hffff_ffff;
        limit = neg_d ? EXT_W'(33'h0_8000_0000) : EXT_W'(33'h0_ffff_ffff);
      end
    endcase
    m_val_d     = res_ext[31:0] & smask;
    m_user_d[0] = stop_d || !ds_d;
    m_user_d[1] = acc_ext > limit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      neg_q   <= 1'b0;
      base_q  <= 5'd0;
      phase_q <= PH_START;
      stop_q  <= 1'b0;
      ds_q    <= 1'b0;
    end else if (fire) begin
      if (st_last_q) begin
        acc_q   <= '0;
        neg_q   <= 1'b0;
        base_q  <= 5'd0;
        phase_q <= PH_START;
        stop_q  <= 1'b0;
        ds_q    <= 1'b0;
      end else begin
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        base_q  <= base_d;
        phase_q <= phase_d;
        stop_q  <= stop_d;
        ds_q    <= ds_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (fire && st_last_q) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && st_last_q) begin
      m_val_q  <= m_val_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_val_q;
  assign m_axis_tuser  = m_user_q;

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> st_vld_q)
    else $error("input stalled with empty stage");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && st_last_q) |=> m_axis_tvalid)
    else $error("last item gave no result");

  a_fresh_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && st_last_q) |=> (phase_q == PH_START && !neg_q && !stop_q && !ds_q))
    else $error("state not cleared after last item");

  a_no_digit_bogus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && st_last_q && !ds_d) |=> m_axis_tuser[0])
    else $error("number without digits not flagged");

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the ascii number to integer converter
`timescale 1ns / 1ps

module tb_top;
  import an2i_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        bogus;
    logic        too_large;
  } conv_result_t;

  class conv_scoreboard;
    logic [4:0]   radix;
    logic [1:0]   size_code;
    logic [31:0]  acc;
    logic         neg;
    logic [4:0]   base;
    logic [1:0]   phase;
    logic         stopped;
    logic         seen;
    conv_result_t expected_values[$];
    int           errors;

    function new();
      radix     = RADIX_RST;
      size_code = SIZE_RST;
      errors    = 0;
      clear_number();
    endfunction

    function void clear_number();
      acc     = '0;
      neg     = 1'b0;
      base    = '0;
      phase   = PH_START;
      stopped = 1'b0;
      seen    = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [4:0] data);
      if (idx == CFG_RADIX) begin
        radix = data;
      end else begin
        size_code = data[1:0];
      end
    endfunction

    function void take_digit(logic [7:0] c);
      int v;
      if (stopped) return;
      if (c >= CH_LC_A) begin
        v = int'(c) - int'(CH_LC_A) + 10;
      end else if (c >= CH_UC_A) begin
        v = int'(c) - int'(CH_UC_A) + 10;
      end else if (c >= CH_ZERO) begin
        v = int'(c) - int'(CH_ZERO);
      end else begin
        stopped = 1'b1;
        return;
      end
      if (v >= int'(base)) begin
        stopped = 1'b1;
        return;
      end
      acc  = acc * {27'd0, base} + 32'(v);
      seen = 1'b1;
    endfunction

    function void feed_body(logic [7:0] c);
      if (base == 0) begin
        if (c == CH_ZERO) begin
          phase = PH_ZERO;
          return;
        end
        base = 5'd10;
      end
      phase = PH_DIGITS;
      take_digit(c);
    endfunction

    function void note_char(logic [7:0] c, logic l);
      conv_result_t r;
      int           bits;
      logic [31:0]  smask;
      logic [31:0]  res;
      logic [32:0]  limit;
      case (phase)
        PH_START: begin
          base = radix;
          if (c == CH_MINUS) begin
            neg   = 1'b1;
            phase = PH_SIGNED;
          end else begin
            feed_body(c);
          end
        end
        PH_SIGNED: feed_body(c);
        PH_ZERO: begin
          if (c == CH_X) begin
            base = 5'd16;
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            base = 5'd8;
            take_digit(c);
          end else begin
            base = 5'd10;
            take_digit(CH_ZERO);
            take_digit(c);
          end
          phase = PH_DIGITS;
        end
        default: take_digit(c);
      endcase
      if (!l) return;
      if (phase == PH_ZERO) begin
        base = 5'd10;
        take_digit(CH_ZERO);
      end
      case (size_code)
        SIZE_8:  bits = 8;
        SIZE_16: bits = 16;
        default: bits = 32;
      endcase
      smask = (bits == 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
      limit = neg ? (33'd1 << (bits - 1)) : {1'b0, smask};
      res = neg ? (32'd0 - acc) : acc;
      r.value     = res & smask;
      r.bogus     = stopped || !seen;
      r.too_large = {1'b0, acc} > limit;
      expected_values.push_back(r);
      clear_number();
    endfunction

    function void check_result(logic [31:0] value, logic bogus, logic too_large);
      conv_result_t r;
      if (expected_values.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h bogus %b too_large %b",
                 $time, value, bogus, too_large);
        errors++;
        return;
      end
      r = expected_values.pop_front();
      if (value !== r.value) begin
        $display("%0t value mismatch: expected %h actual %h", $time, r.value, value);
        errors++;
      end
      if (bogus !== r.bogus) begin
        $display("%0t bogus mismatch: expected %b actual %b", $time, r.bogus, bogus);
        errors++;
      end
      if (too_large !== r.too_large) begin
        $display("%0t too_large mismatch: expected %b actual %b", $time, r.too_large,
                 too_large);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [4:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // ch
  logic        s_axis_tlast  = 1'b0; // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // value
  logic [1:0]  m_axis_tuser;         // bogus, too_large

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  conv_scoreboard sb = new();

  ascii_number_to_integer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      sb.write_reg(cfg_idx_i, cfg_data_i);
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_char(s_axis_tdata, s_axis_tlast);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
    end
  end

  task automatic send_item(input logic [7:0] c, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  // hold the sender until every result is out and the pipeline is empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_values.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [4:0] rdx, input logic [1:0] sz);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RADIX;
    cfg_data_i <= rdx;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SIZE;
    cfg_data_i <= {3'($urandom_range(7)), sz};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(int v);
    if (v < 10) return CH_ZERO + 8'(v);
    if ($urandom_range(1)) return CH_LC_A + 8'(v - 10);
    return CH_UC_A + 8'(v - 10);
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(5))
      0: return CH_MINUS;
      1: return CH_ZERO;
      2: return CH_X;
      3: return CH_ZERO + 8'($urandom_range(9));
      4: return CH_LC_A + 8'($urandom_range(5));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_number(input logic [4:0] rdx, inout int sent);
    logic [7:0] txt[$];
    int         base;
    int         len;
    int         v;
    int         pos;
    txt.delete();
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(99) < 30) txt.push_back(CH_MINUS);
      base = rdx;
      if (rdx == 0) begin
        case ($urandom_range(2))
          0: begin
            txt.push_back(CH_ZERO);
            txt.push_back(CH_X);
            base = 16;
          end
          1: begin
            txt.push_back(CH_ZERO);
            base = 8;
          end
          default: base = 10;
        endcase
      end
      len = ($urandom_range(3) == 0) ? $urandom_range(14, 1) : $urandom_range(4, 1);
      for (int i = 0; i < len; i++) begin
        v = (base < 2) ? 0 : $urandom_range(base - 1);
        if (rdx == 0 && base == 10 && i == 0) v = $urandom_range(9, 1);
        txt.push_back(digit_char(v));
      end
      // broken sequence: one character somewhere replaced by a random noise character
      if ($urandom_range(99) < 10) begin
        pos = $urandom_range(txt.size() - 1);
        txt[pos] = noise_char();
      end
    end else begin
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) txt.push_back(noise_char());
    end
    foreach (txt[i]) begin
      send_item(txt[i], i == txt.size() - 1);
    end
    sent += txt.size();
  endtask

  initial begin
    logic [4:0] rdx_tab[10];
    logic [1:0] sz_tab[10];
    int         sent;
    rdx_tab = '{5'd0, 5'd2, 5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd10, 5'd17, 5'd0};
    sz_tab  = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd3};
    rdx_tab[9] = 5'($urandom_range(31));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset setting, then prefix detection with 8-bit size
    send_idle_pct = 6;
    recv_idle_pct = 56;
    send_text("-");
    send_text("9-");
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b1);
    send_text("-7");
    wait_idle();
    apply_setting(5'd0, SIZE_8);
    send_text("0x");
    send_text("0");
    send_text("017");
    send_text("0xff");
    send_text("0z");
    send_text("300");
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      if (p < 3) begin
        send_idle_pct = 6;
        recv_idle_pct = 56;
      end else if (p < 6) begin
        send_idle_pct = 56;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(rdx_tab[p], sz_tab[p]);
      sent = 0;
      while (sent < 35) send_random_number(rdx_tab[p], sent);
      wait_idle();
      while (sent < 70) send_random_number(rdx_tab[p], sent);
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_values.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
